// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Used by files that check their own control state; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define LPMD_ASSERT(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define LPMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lpmd_pkg.sv =====
// Types and constants for the length-prefixed message deframer.
// No dependencies; imported by lpmd_step and the top level.
`default_nettype none

package lpmd_pkg;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_EMPTY    = 2'd1;
	localparam logic [1:0] KIND_OVERSIZE = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT  = 2'd3;

	localparam logic [7:0] REG_TIMEOUT_TICKS = 8'd0;
	localparam logic [7:0] REG_MAX_MSG_LEN   = 8'd1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
	localparam logic [15:0] MAX_LEN_RESET = 16'd1024;
	localparam logic [16:0] IDLE_MAX      = 17'h1FFFF;

	typedef struct packed {
		logic        awaiting_header;
		logic        low_byte_held;
		logic [7:0]  held_low_byte;
		logic [15:0] expected_length;
		logic [15:0] received_count;
		logic        skip_to_packet_end;
		logic [16:0] idle_count;
	} lpmd_state_t;

	localparam lpmd_state_t STATE_RESET = '{
		awaiting_header:    1'b1,
		low_byte_held:      1'b0,
		held_low_byte:      8'd0,
		expected_length:    16'd0,
		received_count:     16'd0,
		skip_to_packet_end: 1'b0,
		idle_count:         17'd0
	};

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic        last_of_message;
		logic [15:0] message_length;
	} lpmd_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpmd_step.sv =====
// Next-state and result logic of the deframer for one request.
// Depends on lpmd_pkg for the state and result structs and codes.
`default_nettype none

module lpmd_step
	import lpmd_pkg::*;
(
	input  wire lpmd_state_t  state,
	input  wire               operation,
	input  wire [7:0]         data_byte,
	input  wire               packet_end,
	input  wire [15:0]        timeout_ticks,
	input  wire [15:0]        max_message_length,
	output lpmd_state_t       next_state,
	output lpmd_result_t      result
);

	logic        in_message;
	logic [16:0] idle_inc;
	logic [15:0] header_len;
	logic [16:0] count_inc;
	logic        is_last;

	assign in_message = !state.awaiting_header || state.low_byte_held;
	assign idle_inc   = (state.idle_count == IDLE_MAX) ? state.idle_count
		: state.idle_count + 17'd1;
	assign header_len = {data_byte, state.held_low_byte};
	assign count_inc  = {1'b0, state.received_count} + 17'd1;
	assign is_last    = count_inc >= {1'b0, state.expected_length};

	always_comb begin
		next_state = state;
		result     = '0;
		if (operation == OP_TICK) begin
			if (!in_message) begin
				next_state.idle_count = 17'd0;
			end else if (idle_inc > {1'b0, timeout_ticks}) begin
				// abort the stalled message; skip flag is untouched
				next_state = STATE_RESET;
				next_state.skip_to_packet_end = state.skip_to_packet_end;
				result.valid = 1'b1;
				result.kind  = KIND_TIMEOUT;
				result.message_length = state.awaiting_header ? 16'd0
					: state.expected_length;
			end else begin
				next_state.idle_count = idle_inc;
			end
		end else begin
			next_state.idle_count = 17'd0;
			if (state.skip_to_packet_end) begin
				if (packet_end)
					next_state.skip_to_packet_end = 1'b0;
			end else if (state.awaiting_header) begin
				if (!state.low_byte_held) begin
					// drop a low header byte that ends its packet
					if (!packet_end) begin
						next_state.held_low_byte = data_byte;
						next_state.low_byte_held = 1'b1;
					end
				end else begin
					next_state.low_byte_held = 1'b0;
					next_state.held_low_byte = 8'd0;
					if (header_len > max_message_length) begin
						next_state = STATE_RESET;
						next_state.skip_to_packet_end = !packet_end;
						result.valid = 1'b1;
						result.kind  = KIND_OVERSIZE;
						result.message_length = header_len;
					end else if (header_len == 16'd0) begin
						result.valid = 1'b1;
						result.kind  = KIND_EMPTY;
						result.last_of_message = 1'b1;
					end else begin
						next_state.expected_length = header_len;
						next_state.received_count  = 16'd0;
						next_state.awaiting_header = 1'b0;
					end
				end
			end else begin
				if (is_last) begin
					next_state = STATE_RESET;
					next_state.skip_to_packet_end = state.skip_to_packet_end;
				end else begin
					next_state.received_count = count_inc[15:0];
				end
				result.valid           = 1'b1;
				result.kind            = KIND_PAYLOAD;
				result.payload_byte    = data_byte;
				result.byte_index      = state.received_count;
				result.last_of_message = is_last;
				result.message_length  = state.expected_length;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/length_prefixed_message_deframer_core.sv =====
// Length-prefixed message deframer, top level.
// Depends on lpmd_pkg, lpmd_step and assert_macros.svh.
//
// Input channel (in_valid/in_ready): one request per accepted item, either a
// received byte (operation 0) with its packet_end mark, or a timer tick
// (operation 1). Each message is a 2-byte little-endian length header and
// then that many payload bytes, possibly across link packets.
// Output channel (out_valid/out_ready): at most one result per request:
// a payload byte with its index, an empty message, an oversize abort or a
// timeout abort. A result is registered and appears in the cycle after its
// request is accepted. Throughput is one request per cycle: the state update is
// a single pass of counter and compare logic, and the result register takes a
// new result in the cycle its current one is taken. When the receiver stalls
// with a result held, in_ready drops until that result is taken.
// Configuration (cfg_valid/cfg_ready): index 0 writes timeout_ticks, index 1
// writes max_message_length; other indexes are ignored. cfg_ready is always
// high. Write only while no request is in flight.
// Reset clears the framing state, empties the result register and loads
// timeout_ticks = 3000 and max_message_length = 1024.
`default_nettype none

`include "assert_macros.svh"

module length_prefixed_message_deframer_core
	import lpmd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,

	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_index,
	input  wire  [15:0] cfg_data,

	input  wire         in_valid,
	output logic        in_ready,
	input  wire         operation,
	input  wire  [7:0]  data_byte,
	input  wire         packet_end,

	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] byte_index,
	output logic        last_of_message,
	output logic [15:0] message_length
);

	logic [15:0]  timeout_ticks_q;
	logic [15:0]  max_len_q;
	lpmd_state_t  state_q;
	lpmd_state_t  state_next;
	lpmd_result_t step_res;
	lpmd_result_t res_q;
	logic         in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !res_q.valid || out_ready;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_RESET;
			max_len_q       <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				REG_MAX_MSG_LEN:   max_len_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	lpmd_step u_step (
		.state              (state_q),
		.operation          (operation),
		.data_byte          (data_byte),
		.packet_end         (packet_end),
		.timeout_ticks      (timeout_ticks_q),
		.max_message_length (max_len_q),
		.next_state         (state_next),
		.result             (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_fire) begin
			state_q <= state_next;
		end
	end

	// result register: load the fields only with a result, hold them otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (in_fire) begin
			if (step_res.valid) begin
				res_q <= step_res;
			end else begin
				res_q.valid <= 1'b0;
			end
		end else if (out_ready) begin
			res_q.valid <= 1'b0;
		end
	end

	assign out_valid       = res_q.valid;
	assign kind            = res_q.kind;
	assign payload_byte    = res_q.payload_byte;
	assign byte_index      = res_q.byte_index;
	assign last_of_message = res_q.last_of_message;
	assign message_length  = res_q.message_length;

	`LPMD_ASSERT(a_low_byte_only_in_header, clk, arst_n,
		!state_q.low_byte_held || state_q.awaiting_header,
		"low header byte held while receiving a body")
	`LPMD_ASSERT(a_skip_only_in_header, clk, arst_n,
		!state_q.skip_to_packet_end || (state_q.awaiting_header && !state_q.low_byte_held),
		"packet skip active inside a message")
	`LPMD_ASSERT(a_count_below_length, clk, arst_n,
		state_q.awaiting_header || (state_q.received_count < state_q.expected_length),
		"received count reached expected length inside a body")
	`LPMD_ASSERT(a_header_clears_body, clk, arst_n,
		!state_q.awaiting_header || (state_q.received_count == 16'd0),
		"received count not cleared while awaiting a header")
	`LPMD_ASSERT_NEXT(a_result_registered, clk, arst_n,
		in_fire && step_res.valid, res_q.valid,
		"accepted request with a result did not load the result register")

endmodule

`default_nettype wire
